[hdl/tob_pkg.sv]
// ---------------------------------------------------------------------------
// tob_pkg
// Shared widths, codes and types of the tick to OHLCV bar aggregator.
// ---------------------------------------------------------------------------
package tob_pkg;

    // field widths
    localparam int TS_W      = 63;
    localparam int PRICE_W   = 32;
    localparam int VOL_W     = 32;
    localparam int IV_W      = 48;
    localparam int BAR_VOL_W = 48;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 240;

    // remainder step counter
    localparam int CNT_W = $clog2(TS_W);

    // input item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // interval after reset, in ns
    localparam logic [IV_W-1:0] BAR_INTERVAL_RESET = IV_W'(64'd1000000000);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // front sequencer states
    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIVIDE,
        FRONT_PUSH
    } t_front_state;

    // classified item handed from front to back
    typedef struct packed {
        logic               func;
        logic [TS_W-1:0]    start;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   vol;
    } t_bar_op;

endpackage

[hdl/tick_to_ohlcv_bar_aggregator.sv]
// ---------------------------------------------------------------------------
// tick_to_ohlcv_bar_aggregator
// Groups time-ordered trade ticks into OHLCV time bars.
// ---------------------------------------------------------------------------
// A trade tick occupies the input from its transfer until the next one: the
// front floors its timestamp to a multiple of the bar interval with a
// bit-serial remainder unit that takes one timestamp bit per cycle, then
// hands the item to a two-entry queue. A flush goes straight to the queue. The
// back side updates the open bar with each item and holds a finished bar in an
// output register, so a stalled output only stops the front once the queue is
// full. The bar interval is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, which the block does not enforce; zero acts as one.
module tick_to_ohlcv_bar_aggregator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_wr_en,
    input  logic [tob_pkg::IV_W-1:0]           i_cfg_wr_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tick_ts[62:0], trade_price[94:63], trade_volume[126:95], zero [127]
    input  logic [tob_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // func[0]
    input  logic                               s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // bar_begin_ts[62:0], open_price[94:63], high_price[126:95], low_price[158:127],
    // close_price[190:159], bar_volume[238:191], zero [239]
    output logic [tob_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int PRICE_LO = tob_pkg::TS_W;
    localparam int VOL_LO   = PRICE_LO + tob_pkg::PRICE_W;

    logic [tob_pkg::IV_W-1:0]  r_bar_interval;

    logic              w_fr_valid;
    logic              w_fr_ready;
    tob_pkg::t_bar_op  w_fr_op;
    logic              w_q_valid;
    logic              w_q_ready;
    tob_pkg::t_bar_op  w_q_op;

    // interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_interval <= tob_pkg::BAR_INTERVAL_RESET;
        end else if (i_cfg_wr_en) begin
            r_bar_interval <= i_cfg_wr_data;
        end
    end

    // front: accept and floor
    tob_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_ts       (s_axis_tdata[tob_pkg::TS_W-1:0]),
        .i_price    (s_axis_tdata[PRICE_LO +: tob_pkg::PRICE_W]),
        .i_vol      (s_axis_tdata[VOL_LO +: tob_pkg::VOL_W]),
        .i_interval (r_bar_interval),
        .o_op_valid (w_fr_valid),
        .i_op_ready (w_fr_ready),
        .o_op       (w_fr_op)
    );

    // queue between the two sides
    tob_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_op    (w_fr_op),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_op    (w_q_op)
    );

    // back: bar update and output
    tob_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_q_valid),
        .o_op_ready  (w_q_ready),
        .i_op        (w_q_op),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[hdl/tob_front.sv]
// ---------------------------------------------------------------------------
// tob_front
// Accepts input items and floors each tick's timestamp to its bar start
// with a bit-serial remainder unit, then pushes the item to the queue.
// ---------------------------------------------------------------------------
module tob_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [tob_pkg::TS_W-1:0]      i_ts,
    input  logic [tob_pkg::PRICE_W-1:0]   i_price,
    input  logic [tob_pkg::VOL_W-1:0]     i_vol,
    input  logic [tob_pkg::IV_W-1:0]      i_interval,
    output logic                          o_op_valid,
    input  logic                          i_op_ready,
    output tob_pkg::t_bar_op              o_op
);

    localparam logic [tob_pkg::CNT_W-1:0] CNT_LAST = tob_pkg::CNT_W'(tob_pkg::TS_W - 1);

    tob_pkg::t_front_state r_state, n_state;

    logic                          r_func;
    logic [tob_pkg::TS_W-1:0]      r_ts;
    logic [tob_pkg::PRICE_W-1:0]   r_price;
    logic [tob_pkg::VOL_W-1:0]     r_vol;
    logic [tob_pkg::IV_W-1:0]      r_iv;
    logic [tob_pkg::IV_W-1:0]      r_rem;
    logic [tob_pkg::CNT_W-1:0]     r_cnt;

    logic                          w_accept;
    logic [tob_pkg::IV_W:0]        w_trial;
    logic [tob_pkg::IV_W:0]        w_diff;
    logic                          w_fits;

    assign w_accept = i_valid && o_ready;

    // one remainder step: shift in the next timestamp bit, subtract if it fits
    assign w_trial = {r_rem, r_ts[r_cnt]};
    assign w_diff  = w_trial - {1'b0, r_iv};
    assign w_fits  = w_trial >= {1'b0, r_iv};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tob_pkg::FRONT_IDLE: begin
                if (w_accept) begin
                    n_state = (i_func == tob_pkg::FUNC_FLUSH) ? tob_pkg::FRONT_PUSH
                                                              : tob_pkg::FRONT_DIVIDE;
                end
            end
            tob_pkg::FRONT_DIVIDE: begin
                if (r_cnt == '0) begin
                    n_state = tob_pkg::FRONT_PUSH;
                end
            end
            tob_pkg::FRONT_PUSH: begin
                if (i_op_ready) begin
                    n_state = tob_pkg::FRONT_IDLE;
                end
            end
            default: n_state = tob_pkg::FRONT_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready    = 1'b0;
        o_op_valid = 1'b0;
        unique case (r_state)
            tob_pkg::FRONT_IDLE:   o_ready    = 1'b1;
            tob_pkg::FRONT_DIVIDE: o_ready    = 1'b0;
            tob_pkg::FRONT_PUSH:   o_op_valid = 1'b1;
            default:               o_ready    = 1'b0;
        endcase
    end

    // bar start is the timestamp less its remainder
    always_comb begin
        o_op.func  = r_func;
        o_op.start = r_ts - {{(tob_pkg::TS_W - tob_pkg::IV_W){1'b0}}, r_rem};
        o_op.price = r_price;
        o_op.vol   = r_vol;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tob_pkg::FRONT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item capture and remainder iteration
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_ts    <= i_ts;
            r_price <= i_price;
            r_vol   <= i_vol;
            // zero interval acts as one
            r_iv    <= (i_interval == '0) ? tob_pkg::IV_W'(1) : i_interval;
            r_rem   <= '0;
            r_cnt   <= CNT_LAST;
        end else if (r_state == tob_pkg::FRONT_DIVIDE) begin
            r_rem <= w_fits ? w_diff[tob_pkg::IV_W-1:0] : w_trial[tob_pkg::IV_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

[hdl/tob_queue.sv]
// ---------------------------------------------------------------------------
// tob_queue
// Short first-in first-out queue of classified items between front and back.
// ---------------------------------------------------------------------------
module tob_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tob_pkg::t_bar_op  i_op,
    output logic              o_valid,
    input  logic              i_ready,
    output tob_pkg::t_bar_op  o_op
);

    tob_pkg::t_bar_op                r_mem [tob_pkg::Q_DEPTH];
    logic [tob_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [tob_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [tob_pkg::Q_PTR_W:0]       r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = r_count != (tob_pkg::Q_PTR_W + 1)'(tob_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_op    = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

[hdl/tob_back.sv]
// ---------------------------------------------------------------------------
// tob_back
// Keeps the open bar, updates it with each item and registers finished bars
// on the output stream.
// ---------------------------------------------------------------------------
module tob_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_op_valid,
    output logic                               o_op_ready,
    input  tob_pkg::t_bar_op                   i_op,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tob_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int PAD_W = tob_pkg::OUT_DATA_W - tob_pkg::TS_W - 4 * tob_pkg::PRICE_W
                           - tob_pkg::BAR_VOL_W;

    logic                              r_bar_open;
    logic [tob_pkg::TS_W-1:0]          r_start;
    logic [tob_pkg::PRICE_W-1:0]       r_open;
    logic [tob_pkg::PRICE_W-1:0]       r_high;
    logic [tob_pkg::PRICE_W-1:0]       r_low;
    logic [tob_pkg::PRICE_W-1:0]       r_close;
    logic [tob_pkg::BAR_VOL_W-1:0]     r_vol;
    logic                              r_out_valid;
    logic [tob_pkg::OUT_DATA_W-1:0]    r_out_data;

    logic                              w_pop;
    logic                              w_flush;
    logic                              w_new_bar;
    logic                              w_emit;
    logic [tob_pkg::BAR_VOL_W:0]       w_vol_sum;
    logic [tob_pkg::BAR_VOL_W-1:0]     w_vol_sat;

    assign o_op_ready  = !r_out_valid || i_out_ready;
    assign w_pop       = i_op_valid && o_op_ready;
    assign w_flush     = i_op.func == tob_pkg::FUNC_FLUSH;
    assign w_new_bar   = !r_bar_open || (i_op.start != r_start);
    assign w_emit      = r_bar_open && (w_flush || (i_op.start != r_start));
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // running volume with saturation
    assign w_vol_sum = {1'b0, r_vol} + (tob_pkg::BAR_VOL_W + 1)'(i_op.vol);
    assign w_vol_sat = w_vol_sum[tob_pkg::BAR_VOL_W] ? '1 : w_vol_sum[tob_pkg::BAR_VOL_W-1:0];

    // open bar flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_open <= 1'b0;
        end else if (w_pop) begin
            r_bar_open <= !w_flush;
        end
    end

    // bar contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_open  <= '0;
            r_high  <= '0;
            r_low   <= '0;
            r_close <= '0;
            r_vol   <= '0;
        end else if (w_pop) begin
            if (w_flush) begin
                r_start <= '0;
                r_open  <= '0;
                r_high  <= '0;
                r_low   <= '0;
                r_close <= '0;
                r_vol   <= '0;
            end else if (w_new_bar) begin
                r_start <= i_op.start;
                r_open  <= i_op.price;
                r_high  <= i_op.price;
                r_low   <= i_op.price;
                r_close <= i_op.price;
                r_vol   <= tob_pkg::BAR_VOL_W'(i_op.vol);
            end else begin
                if (i_op.price > r_high) begin
                    r_high <= i_op.price;
                end
                if (i_op.price < r_low) begin
                    r_low <= i_op.price;
                end
                r_close <= i_op.price;
                r_vol   <= w_vol_sat;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_emit) begin
            r_out_data <= {{PAD_W{1'b0}}, r_vol, r_close, r_low, r_high, r_open, r_start};
        end
    end

endmodule

[hdl/tob_checker.sv]
// ---------------------------------------------------------------------------
// tob_checker
// Port-level checks of the bar aggregator, bound to the top level.
// ---------------------------------------------------------------------------
module tob_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [tob_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic [tob_pkg::PRICE_W-1:0] w_open;
    logic [tob_pkg::PRICE_W-1:0] w_high;
    logic [tob_pkg::PRICE_W-1:0] w_low;
    logic [tob_pkg::PRICE_W-1:0] w_close;

    assign w_open  = m_axis_tdata[63 +: tob_pkg::PRICE_W];
    assign w_high  = m_axis_tdata[95 +: tob_pkg::PRICE_W];
    assign w_low   = m_axis_tdata[127 +: tob_pkg::PRICE_W];
    assign w_close = m_axis_tdata[159 +: tob_pkg::PRICE_W];

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // high and low bound the other prices of a finished bar
    a_bar_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_high >= w_low) && (w_high >= w_open) && (w_high >= w_close)
                          && (w_low <= w_open) && (w_low <= w_close))
        else $error("bar high/low inconsistent with open/close");

    // an accepted item occupies the front for at least the next cycle
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("front took items in consecutive cycles");

endmodule

bind tick_to_ohlcv_bar_aggregator tob_checker u_tob_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the tick to OHLCV bar aggregator against a cycle-free bar predictor.
// A queue of pending transfers and interval writes is filled up front: a
// directed part covers the extremes, flush with and without an open bar, the
// zero interval, out-of-order ticks and an interval change mid-bar. Random
// phases follow, each with its own interval, made mostly of ordered tick runs
// with noise ticks and flushes mixed in. Every finished bar is compared field
// by field with the oldest predicted bar.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int QUIET_LO      = 15000;
    localparam int QUIET_HI      = 30000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;

    // one finished bar
    typedef struct packed {
        logic [tob_pkg::TS_W-1:0]      start;
        logic [tob_pkg::PRICE_W-1:0]   open_px;
        logic [tob_pkg::PRICE_W-1:0]   high_px;
        logic [tob_pkg::PRICE_W-1:0]   low_px;
        logic [tob_pkg::PRICE_W-1:0]   close_px;
        logic [tob_pkg::BAR_VOL_W-1:0] volume;
    } t_bar;

    // one pending entry: a stream transfer or an interval write
    typedef struct packed {
        logic                        is_cfg;
        logic [tob_pkg::IV_W-1:0]    cfg_value;
        logic                        func;
        logic [tob_pkg::TS_W-1:0]    ts;
        logic [tob_pkg::PRICE_W-1:0] price;
        logic [tob_pkg::VOL_W-1:0]   vol;
    } t_tick_entry;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [tob_pkg::IV_W-1:0]       i_cfg_wr_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [tob_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [tob_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    t_tick_entry pending_ticks[$];
    t_bar        expected_bars[$];
    t_tick_entry cur_entry = '0;
    int          ticks_left = 0;
    int          settle_cycles = 0;
    int          cycle_count = 0;
    int          error_count = 0;
    logic        gaps_on;

    // predictor state
    logic [tob_pkg::IV_W-1:0] interval_ns = tob_pkg::BAR_INTERVAL_RESET;
    logic                     bar_is_open = 1'b0;
    t_bar                     open_bar = '0;

    tick_to_ohlcv_bar_aggregator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock and cycle count
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    assign gaps_on = !(cycle_count >= QUIET_LO && cycle_count < QUIET_HI);

    // bar update for one accepted transfer, returns 1 when a bar is finished
    function automatic bit bar_advance(input t_tick_entry it, output t_bar finished);
        logic [63:0]                 iv;
        logic [63:0]                 floor_ts;
        logic [tob_pkg::BAR_VOL_W:0] vsum;
        bit                          emitted;
        emitted  = 1'b0;
        finished = '0;
        if (it.func == tob_pkg::FUNC_FLUSH) begin
            if (bar_is_open) begin
                finished = open_bar;
                emitted  = 1'b1;
            end
            bar_is_open = 1'b0;
            open_bar    = '0;
        end else begin
            // zero interval floors like an interval of one
            iv       = (interval_ns == '0) ? 64'd1 : {16'd0, interval_ns};
            floor_ts = ({1'b0, it.ts} / iv) * iv;
            if (!bar_is_open || floor_ts[tob_pkg::TS_W-1:0] != open_bar.start) begin
                if (bar_is_open) begin
                    finished = open_bar;
                    emitted  = 1'b1;
                end
                bar_is_open       = 1'b1;
                open_bar.start    = floor_ts[tob_pkg::TS_W-1:0];
                open_bar.open_px  = it.price;
                open_bar.high_px  = it.price;
                open_bar.low_px   = it.price;
                open_bar.close_px = it.price;
                open_bar.volume   = tob_pkg::BAR_VOL_W'(it.vol);
            end else begin
                if (it.price > open_bar.high_px) open_bar.high_px = it.price;
                if (it.price < open_bar.low_px) open_bar.low_px = it.price;
                open_bar.close_px = it.price;
                // volume saturates at all ones
                vsum = {1'b0, open_bar.volume} + (tob_pkg::BAR_VOL_W + 1)'(it.vol);
                open_bar.volume = vsum[tob_pkg::BAR_VOL_W] ? '1
                                                            : vsum[tob_pkg::BAR_VOL_W-1:0];
            end
        end
        return emitted;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // stimulus queue fillers
    task automatic add_tick(input logic [tob_pkg::TS_W-1:0] ts,
                            input logic [tob_pkg::PRICE_W-1:0] price,
                            input logic [tob_pkg::VOL_W-1:0] vol);
        t_tick_entry e;
        e       = '0;
        e.func  = tob_pkg::FUNC_TICK;
        e.ts    = ts;
        e.price = price;
        e.vol   = vol;
        pending_ticks.insert(pending_ticks.size(), e);
        ticks_left++;
    endtask

    // flush operands are random, they must not matter
    task automatic add_flush();
        t_tick_entry e;
        e       = '0;
        e.func  = tob_pkg::FUNC_FLUSH;
        e.ts    = tob_pkg::TS_W'({$urandom, $urandom});
        e.price = $urandom;
        e.vol   = $urandom;
        pending_ticks.insert(pending_ticks.size(), e);
        ticks_left++;
    endtask

    task automatic add_interval(input logic [tob_pkg::IV_W-1:0] value);
        t_tick_entry e;
        e           = '0;
        e.is_cfg    = 1'b1;
        e.cfg_value = value;
        pending_ticks.insert(pending_ticks.size(), e);
    endtask

    // driver: input transfers and interval writes, writes only once drained
    always @(posedge i_clk) begin : driver
        t_bar finished;
        bit   hold;
        bit   cfg_go;
        if (i_rst_n) begin
            cfg_go = 1'b0;
            hold   = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                if (bar_advance(cur_entry, finished)) begin
                    expected_bars.insert(expected_bars.size(), finished);
                end
                ticks_left--;
                settle_cycles = 0;
            end else if (settle_cycles < DRAIN_CYCLES) begin
                settle_cycles++;
            end
            if (!hold && pending_ticks.size() != 0) begin
                if (pending_ticks[0].is_cfg) begin
                    if (expected_bars.size() == 0 && settle_cycles >= DRAIN_CYCLES) begin
                        cfg_go        = 1'b1;
                        interval_ns   = pending_ticks[0].cfg_value;
                        i_cfg_wr_data <= pending_ticks[0].cfg_value;
                        void'(pending_ticks.pop_front());
                        settle_cycles = 0;
                    end
                end else if (!(gaps_on && $urandom_range(99) < 14)) begin
                    cur_entry = pending_ticks.pop_front();
                    hold      = 1'b1;
                end
            end
            s_axis_tvalid <= hold;
            s_axis_tdata  <= {1'b0, cur_entry.vol, cur_entry.price, cur_entry.ts};
            s_axis_tuser  <= cur_entry.func;
            i_cfg_wr_en   <= cfg_go;
        end
    end

    // monitor: compare each finished bar with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_bar got;
        t_bar want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.start    = m_axis_tdata[62:0];
                got.open_px  = m_axis_tdata[94:63];
                got.high_px  = m_axis_tdata[126:95];
                got.low_px   = m_axis_tdata[158:127];
                got.close_px = m_axis_tdata[190:159];
                got.volume   = m_axis_tdata[238:191];
                if (expected_bars.size() == 0) begin
                    $display("%0t: unexpected bar, expected none, actual %0h", $time,
                             m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_bars.pop_front();
                    check_field("bar_begin_ts", 64'(want.start), 64'(got.start));
                    check_field("open_price", 64'(want.open_px), 64'(got.open_px));
                    check_field("high_price", 64'(want.high_px), 64'(got.high_px));
                    check_field("low_price", 64'(want.low_px), 64'(got.low_px));
                    check_field("close_price", 64'(want.close_px), 64'(got.close_px));
                    check_field("bar_volume", 64'(want.volume), 64'(got.volume));
                end
            end
            m_axis_tready <= !(gaps_on && $urandom_range(99) < 14);
        end
    end

    // stimulus, reset and end of run
    initial begin : sequencer
        logic [tob_pkg::IV_W-1:0]    phase_iv[PHASES];
        logic [63:0]                 eff_iv;
        logic [63:0]                 advance;
        logic [tob_pkg::TS_W-1:0]    ts_cursor;
        logic [tob_pkg::PRICE_W-1:0] px;
        logic [tob_pkg::VOL_W-1:0]   vol;
        int                          r;

        // directed: flush with no open bar, then extremes in one bar
        add_flush();
        add_tick(63'd0, 32'd100, 32'd0);
        add_tick(63'd999_999_999, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_tick(63'd500, 32'd0, 32'hFFFF_FFFF);
        add_tick(63'd1_000_000_000, 32'd7, 32'd1);
        // out-of-order tick back in the first bar's interval, which opens a new bar
        add_tick(63'd500_000_000, 32'd9, 32'd2);
        add_flush();
        add_flush();
        // zero interval at the top of the timestamp range
        add_interval(48'd0);
        add_tick({tob_pkg::TS_W{1'b1}}, 32'd1, 32'd1);
        add_tick({tob_pkg::TS_W{1'b1}}, 32'd2, 32'd2);
        add_tick({tob_pkg::TS_W{1'b1}} - 63'd1, 32'd3, 32'd3);
        // interval change with a bar still open
        add_interval({tob_pkg::IV_W{1'b1}});
        add_tick({tob_pkg::TS_W{1'b1}}, 32'd4, 32'd4);
        add_tick({tob_pkg::TS_W{1'b1}}, 32'hFFFF_FFFF, 32'd5);
        add_flush();
        add_interval(48'd1);
        add_tick(63'd3, 32'd10, 32'd1);
        add_tick(63'd3, 32'd5, 32'd1);
        add_tick(63'd4, 32'd6, 32'd1);
        add_flush();

        // random phases, one interval each
        phase_iv[0] = 48'd0;
        phase_iv[1] = 48'd1;
        phase_iv[2] = 48'd13;
        phase_iv[3] = 48'd1000;
        phase_iv[4] = tob_pkg::BAR_INTERVAL_RESET;
        phase_iv[5] = {16'($urandom_range(0, 65535)), 32'($urandom)};
        phase_iv[6] = {tob_pkg::IV_W{1'b1}};
        phase_iv[7] = 48'($urandom_range(2, 5000));
        px = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            add_interval(phase_iv[p]);
            eff_iv    = (phase_iv[p] == '0) ? 64'd1 : {16'd0, phase_iv[p]};
            ts_cursor = tob_pkg::TS_W'({$urandom, $urandom});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                // price mostly walks, sometimes jumps anywhere
                if ($urandom_range(9) == 0) px = $urandom;
                else px = px + 32'($urandom_range(0, 200)) - 32'd100;
                vol = ($urandom_range(9) < 7) ? 32'($urandom) : 32'($urandom_range(0, 1000));
                if (r < 5) begin
                    add_flush();
                end else if (r < 12) begin
                    // noise: a tick anywhere in time
                    add_tick(tob_pkg::TS_W'({$urandom, $urandom}), px, vol);
                end else begin
                    r = $urandom_range(99);
                    if (r < 70) advance = (eff_iv * 64'($urandom_range(0, 30))) / 64'd100;
                    else if (r < 90) advance = eff_iv * 64'($urandom_range(1, 2));
                    else advance = 64'd0;
                    ts_cursor = ts_cursor + advance[tob_pkg::TS_W-1:0];
                    add_tick(ts_cursor, px, vol);
                end
            end
            // some phases end with a bar left open across the interval write
            if ($urandom_range(1) == 1) add_flush();
        end
        add_flush();

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ticks_left != 0 || expected_bars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
